// File: rtl/tseq_pkg.sv
// Shared types, codes and helper functions for the time-sorted event queue.
package tseq_pkg;

	// Defaults for the top-level parameters
	localparam int DEPTH_DEF  = 64;
	localparam int TIME_W_DEF = 32;

	// Fixed widths of the result fields
	localparam int COUNT_W = 7;
	localparam int DELTA_W = 32;

	// MIDI status constants
	localparam logic [7:0] HI_NIBBLE  = 8'hF0;
	localparam logic [7:0] ST_NOTEOFF = 8'h80;
	localparam logic [7:0] ST_NOTEON  = 8'h90;
	localparam logic [7:0] ST_PROGCHG = 8'hC0;

	// Coded insert kinds
	localparam logic [1:0] KIND_NOTEOFF = 2'd0;
	localparam logic [1:0] KIND_NOTEON  = 2'd1;

	typedef enum logic [1:0] {
		OP_INS_CODED = 2'd0,
		OP_INS_RAW   = 2'd1,
		OP_DRAIN     = 2'd2,
		OP_CLEAR     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		RK_INSERTED = 3'd0,
		RK_FULL     = 3'd1,
		RK_EMITTED  = 3'd2,
		RK_EMPTY    = 3'd3,
		RK_CLEARED  = 3'd4
	} rk_t;

	// Command word
	typedef struct packed {
		op_t               operation;
		logic [1:0]        event_kind;
		logic [3:0]        channel;
		logic [7:0]        raw_status;
		logic [7:0]        pitch;
		logic signed [7:0] pitch_offset;
		logic [7:0]        velocity;
		logic [31:0]       event_time;
	} cmd_word_t;

	// Result word
	typedef struct packed {
		rk_t                  result_kind;
		logic [DELTA_W-1:0]   delta_time;
		logic [7:0]           status_out;
		logic [7:0]           pitch_out;
		logic [7:0]           velocity_out;
		logic [1:0]           data_bytes;
		logic [COUNT_W-1:0]   note_off_count;
		logic [COUNT_W-1:0]   entry_count;
		logic                 last;
	} res_word_t;

	// Event bytes held per table entry
	typedef struct packed {
		logic [7:0] status;
		logic [7:0] pitch;
		logic [7:0] velocity;
	} entry_data_t;

	// Compare flags of the shared subtractor
	typedef struct packed {
		logic lt;
		logic eq;
	} alu_flags_t;

	function automatic logic [7:0] coded_status(input logic [1:0] kind,
		input logic [3:0] chan);
		logic [7:0] base;
		case (kind)
			KIND_NOTEOFF: base = ST_NOTEOFF;
			KIND_NOTEON:  base = ST_NOTEON;
			default:      base = ST_PROGCHG;
		endcase
		return base | {4'h0, chan};
	endfunction

	function automatic logic [1:0] data_len(input logic [7:0] status);
		return ((status & HI_NIBBLE) == ST_PROGCHG) ? 2'd1 : 2'd2;
	endfunction

	function automatic logic is_note_off(input logic [7:0] status);
		return (status & HI_NIBBLE) == ST_NOTEOFF;
	endfunction

endpackage

// File: rtl/tseq_alu.sv
// Shared time subtractor: difference, less-than and equal for search and drain.
module tseq_alu #(
	parameter int TW = 32
) (
	input  logic [TW-1:0]          a,
	input  logic [TW-1:0]          b,
	output logic [TW-1:0]          diff,
	output tseq_pkg::alu_flags_t   flags
);
	import tseq_pkg::*;

	logic [TW:0] ext;

	// One subtract gives the delta and the borrow used as less-than
	assign ext      = {1'b0, a} - {1'b0, b};
	assign diff     = ext[TW-1:0];
	assign flags.lt = ext[TW];
	assign flags.eq = (a == b);

endmodule

// File: rtl/tseq_table.sv
// Event table memory: one write port, one read port with registered read data.
module tseq_table #(
	parameter int DEPTH = 64,
	parameter int TW    = 32,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic [TW-1:0]           wtime,
	input  tseq_pkg::entry_data_t   wdata,
	input  logic [AW-1:0]           raddr,
	output logic [TW-1:0]           rtime,
	output tseq_pkg::entry_data_t   rdata
);
	import tseq_pkg::*;

	logic [TW-1:0] time_mem [DEPTH];
	entry_data_t   data_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			time_mem[waddr] <= wtime;
			data_mem[waddr] <= wdata;
		end
		rtime <= time_mem[raddr];
		rdata <= data_mem[raddr];
	end

endmodule

// File: rtl/time_sorted_event_queue.sv
// Time-sorted event queue top level: sequencer, table memory and shared subtractor.
//
// Holds up to TABLE_DEPTH MIDI events sorted by time in a single-port-read
// memory. A command word is taken when start is high and busy is low; busy
// stays high until the last result word has been issued. Each result word is
// shown for exactly one cycle with valid high and cannot be held off.
// Clear, a rejected insert and a drain of an empty table are answered with a
// single result word straight from the idle state. An insert compares entries
// from the head until the insertion point is found (one memory read and one
// compare each), then moves each entry from the insertion point up by one slot
// (a read, then a write through the one memory port); the final shift step
// writes the new event and issues the result. Entries searched past are never
// moved, so the worst case is an event earlier than the head. A drain reads
// the head entry at the accepting edge, then emits one word per cycle. The
// table contents are not cleared by reset or by clear; only the fill count
// is.
module time_sorted_event_queue #(
	parameter int TABLE_DEPTH = tseq_pkg::DEPTH_DEF,
	parameter int TIME_WIDTH  = tseq_pkg::TIME_W_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  tseq_pkg::cmd_word_t   command,
	output logic                  busy,
	output logic                  valid,
	output tseq_pkg::res_word_t   result
);
	import tseq_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int TW = TIME_WIDTH;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SEARCH = 5'b00010,
		S_SHIFT  = 5'b00100,
		S_MOVE   = 5'b01000,
		S_DRAIN  = 5'b10000
	} state_t;

	state_t        state_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] noff_q;
	logic [TW-1:0] time_q;
	logic [TW-1:0] running_q;
	entry_data_t   new_q;
	logic          valid_q;
	res_word_t     result_q;

	logic [CW-1:0] pos_inc;
	logic [CW-1:0] idx_inc;
	logic [CW-1:0] idx_dec;
	logic [CW-1:0] noff_next;

	logic          res_fire;
	res_word_t     res_d;

	logic          we;
	logic [AW-1:0] waddr;
	logic [TW-1:0] wtime;
	entry_data_t   wdata;
	logic [AW-1:0] raddr;
	logic [TW-1:0] rtime;
	entry_data_t   rdata;

	logic [TW-1:0] alu_b;
	logic [TW-1:0] diff;
	alu_flags_t    flags;

	tseq_table #(
		.DEPTH (TABLE_DEPTH),
		.TW    (TW)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wtime (wtime),
		.wdata (wdata),
		.raddr (raddr),
		.rtime (rtime),
		.rdata (rdata)
	);

	tseq_alu #(
		.TW (TW)
	) u_alu (
		.a     (rtime),
		.b     (alu_b),
		.diff  (diff),
		.flags (flags)
	);

	assign pos_inc   = pos_q + CW'(1);
	assign idx_inc   = idx_q + CW'(1);
	assign idx_dec   = idx_q - CW'(1);
	assign noff_next = noff_q + CW'(is_note_off(rdata.status));

	// Search compares against the new time, drain against the previous event
	assign alu_b = (state_q == S_DRAIN) ? running_q : time_q;

	// Memory port steering
	always_comb begin
		raddr = '0;
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wtime = rtime;
		wdata = rdata;
		unique case (state_q)
			S_IDLE:   raddr = '0;
			S_SEARCH: raddr = pos_inc[AW-1:0];
			S_SHIFT: begin
				raddr = idx_dec[AW-1:0];
				if (idx_q == pos_q) begin
					we    = 1'b1;
					waddr = pos_q[AW-1:0];
					wtime = time_q;
					wdata = new_q;
				end
			end
			S_MOVE:   we = 1'b1;
			S_DRAIN:  raddr = idx_inc[AW-1:0];
			default:  raddr = '0;
		endcase
	end

	// Next result word and its strobe
	always_comb begin
		res_fire = 1'b0;
		res_d    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (command.operation) inside
						OP_INS_CODED, OP_INS_RAW: begin
							if (fill_q == CW'(TABLE_DEPTH)) begin
								res_fire          = 1'b1;
								res_d.result_kind = RK_FULL;
								res_d.entry_count = COUNT_W'(fill_q);
								res_d.last        = 1'b1;
							end
						end
						OP_DRAIN: begin
							if (fill_q == '0) begin
								res_fire          = 1'b1;
								res_d.result_kind = RK_EMPTY;
								res_d.last        = 1'b1;
							end
						end
						OP_CLEAR: begin
							res_fire          = 1'b1;
							res_d.result_kind = RK_CLEARED;
							res_d.last        = 1'b1;
						end
						default: res_fire = 1'b0;
					endcase
				end
			end
			S_SHIFT: begin
				if (idx_q == pos_q) begin
					res_fire          = 1'b1;
					res_d.result_kind = RK_INSERTED;
					res_d.entry_count = COUNT_W'(fill_q + CW'(1));
					res_d.last        = 1'b1;
				end
			end
			S_DRAIN: begin
				res_fire           = 1'b1;
				res_d.result_kind  = RK_EMITTED;
				res_d.delta_time   = DELTA_W'(diff);
				res_d.status_out   = rdata.status;
				res_d.pitch_out    = rdata.pitch;
				res_d.velocity_out = rdata.velocity;
				res_d.data_bytes   = data_len(rdata.status);
				res_d.entry_count  = COUNT_W'(fill_q);
				if (idx_inc == fill_q) begin
					res_d.note_off_count = COUNT_W'(noff_next);
					res_d.last           = 1'b1;
				end
			end
			default: res_fire = 1'b0;
		endcase
	end

	// Result register: one word per strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			result_q <= '0;
		end else begin
			valid_q  <= res_fire;
			result_q <= res_d;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						unique case (command.operation) inside
							OP_INS_CODED, OP_INS_RAW: begin
								if (fill_q != CW'(TABLE_DEPTH)) begin
									time_q <= TW'(command.event_time);
									if (command.operation == OP_INS_CODED) begin
										new_q <= {coded_status(command.event_kind,
											command.channel), command.pitch,
											command.velocity};
									end else begin
										new_q <= {command.raw_status,
											command.pitch + $unsigned(command.pitch_offset),
											command.velocity};
									end
									pos_q   <= '0;
									idx_q   <= fill_q;
									state_q <= (fill_q == '0) ? S_SHIFT : S_SEARCH;
								end
							end
							OP_DRAIN: begin
								if (fill_q != '0) begin
									idx_q     <= '0;
									noff_q    <= '0;
									running_q <= '0;
									state_q   <= S_DRAIN;
								end
							end
							OP_CLEAR: fill_q <= '0;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				// Walk past entries with smaller time, stop just after an equal one
				S_SEARCH: begin
					if (flags.lt) begin
						pos_q <= pos_inc;
						if (pos_inc == fill_q) begin
							state_q <= S_SHIFT;
						end
					end else if (flags.eq) begin
						pos_q   <= pos_inc;
						state_q <= S_SHIFT;
					end else begin
						state_q <= S_SHIFT;
					end
				end
				// Open a slot from the tail down, then drop the new event in
				S_SHIFT: begin
					if (idx_q == pos_q) begin
						fill_q  <= fill_q + CW'(1);
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MOVE;
					end
				end
				S_MOVE: begin
					idx_q   <= idx_dec;
					state_q <= S_SHIFT;
				end
				// One entry out per cycle
				S_DRAIN: begin
					running_q <= rtime;
					noff_q    <= noff_next;
					if (idx_inc == fill_q) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_inc;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign valid  = valid_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	// The fill count never passes the table size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(TABLE_DEPTH))
		else $error("fill count beyond table size");

	// The final word of a command leaves the block ready, earlier ones do not
	a_last_ready: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result.last |-> !busy)
		else $error("ready state does not match last flag");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !result.last |-> busy)
		else $error("block idle while a drain is still running");

	// Clear answers in the next cycle
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command.operation == OP_CLEAR
		|=> valid && result.result_kind == RK_CLEARED && fill_q == '0)
		else $error("clear did not complete in one cycle");

	// An insert report carries the updated fill count
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result.result_kind == RK_INSERTED
		|-> result.entry_count == COUNT_W'(fill_q))
		else $error("insert count mismatch");
`endif

endmodule
